### hdl/ocss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocss_pkg
// Shared types and field widths for the occupied cell sparse set unit.
// ----------------------------------------------------------------------------
package ocss_pkg;

    // Field widths of the request and result items.
    localparam int unsigned POS_W   = 9;
    localparam int unsigned SLOT_W  = 9;
    localparam int unsigned COUNT_W = 10;

    // Stream data widths, padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;

    // Operation codes carried in the mode field.
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FREE,
        S_HOLD
    } t_state;

    // One result item.
    typedef struct packed {
        logic [COUNT_W-1:0] member_count;
        logic [SLOT_W-1:0]  slot;
        logic               changed;
    } t_result;

endpackage

### hdl/occupied_cell_sparse_set_unit.sv
`timescale 1ns / 1ps
// Results: the slot map read is registered on accept. An add or no-op loads the output
// register in S_LOOK, a changing remove in S_FREE, either in S_HOLD after a stall.
// Requests: a new one is taken only in S_IDLE, once the last is through. A remove also
// passes S_FREE, as the slot map has one write port and a remove can need two writes
// (moved entry, then freed position). Reset: synchronous, active low; a clearing pass
// then sweeps the slot map one entry per cycle; no request is accepted until it ends.
// ----------------------------------------------------------------------------
// occupied_cell_sparse_set_unit
// Sparse set of board cells: a position-to-slot map and a dense member list, each
// in a synchronous memory with a write and a read port, and a member count register.
// ----------------------------------------------------------------------------
module occupied_cell_sparse_set_unit
    import ocss_pkg::*;
#(
    parameter int unsigned CELLS = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream. tdata: [0] mode, [9:1] position, [15:10] zero.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result stream. tdata: [0] changed, [9:1] slot, [19:10] member_count, [23:20] zero.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int unsigned IW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned CW = $clog2(CELLS + 1);
    localparam int unsigned MW = IW + 1;

    // Memories: map entry is {member, slot}; list entry is a position.
    logic [MW-1:0]    mem_map  [CELLS];
    logic [POS_W-1:0] mem_list [CELLS];

    // Control and data registers.
    t_state           r_state, n_state;
    logic [IW-1:0]    r_clr;
    logic [CW-1:0]    r_count, n_count;
    logic             r_mode;
    logic [POS_W-1:0] r_pos;
    logic             r_inrange;
    logic [MW-1:0]    r_map_rd;
    logic [POS_W-1:0] r_list_rd;
    t_result          r_res;
    t_result          r_out;
    logic             r_out_vld;

    // Request fields.
    logic             w_in_mode;
    logic [POS_W-1:0] w_in_pos;
    logic             w_accept;

    // Memory port controls.
    logic             w_map_we;
    logic [IW-1:0]    w_map_waddr;
    logic [MW-1:0]    w_map_wdata;
    logic             w_list_we;
    logic [IW-1:0]    w_list_waddr;
    logic [POS_W-1:0] w_list_wdata;

    // Decision datapath.
    logic             w_member;
    logic [IW-1:0]    w_freed;
    logic [IW-1:0]    w_last;
    logic             w_add_ok;
    logic             w_rem_ok;
    logic             w_move;
    t_result          w_res;
    logic             w_out_free;
    logic             w_out_load;

    assign w_in_mode  = s_tdata[0];
    assign w_in_pos   = s_tdata[POS_W:1];
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_vld || m_tready;

    // Decision on the entries read in the previous cycle.
    always_comb begin
        w_member = r_map_rd[MW-1];
        w_freed  = r_map_rd[IW-1:0];
        w_last   = IW'(r_count - CW'(1));
        w_add_ok = r_inrange && (r_mode == MODE_ADD) && !w_member
                   && (32'(r_count) < CELLS);
        w_rem_ok = r_inrange && (r_mode == MODE_REMOVE) && w_member && (r_count != '0);
        w_move   = w_rem_ok && (w_freed != w_last);
        n_count  = r_count;
        w_res    = '0;
        w_res.member_count = COUNT_W'(r_count);
        if (w_add_ok) begin
            n_count            = r_count + CW'(1);
            w_res.changed      = 1'b1;
            w_res.slot         = SLOT_W'(r_count);
            w_res.member_count = COUNT_W'(n_count);
        end else if (w_rem_ok) begin
            n_count            = r_count - CW'(1);
            w_res.changed      = 1'b1;
            w_res.slot         = SLOT_W'(w_freed);
            w_res.member_count = COUNT_W'(n_count);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == IW'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (w_rem_ok)        n_state = S_FREE;
                else if (w_out_free) n_state = S_IDLE;
                else                 n_state = S_HOLD;
            end
            S_FREE: begin
                n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs: handshake, memory writes and output load.
    always_comb begin
        s_tready     = 1'b0;
        w_map_we     = 1'b0;
        w_map_waddr  = IW'(r_pos);
        w_map_wdata  = '0;
        w_list_we    = 1'b0;
        w_list_waddr = IW'(r_count);
        w_list_wdata = r_pos;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_map_we    = 1'b1;
                w_map_waddr = r_clr;
            end
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_LOOK: begin
                if (w_add_ok) begin
                    w_map_we     = 1'b1;
                    w_map_wdata  = {1'b1, IW'(r_count)};
                    w_list_we    = 1'b1;
                end else if (w_move) begin
                    // The last member takes the freed slot.
                    w_map_we     = 1'b1;
                    w_map_waddr  = IW'(r_list_rd);
                    w_map_wdata  = {1'b1, w_freed};
                    w_list_we    = 1'b1;
                    w_list_waddr = w_freed;
                    w_list_wdata = r_list_rd;
                end
                w_out_load = !w_rem_ok && w_out_free;
            end
            S_FREE: begin
                // Drop the removed position from the map.
                w_map_we   = 1'b1;
                w_out_load = w_out_free;
            end
            S_HOLD: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // Slot map memory.
    always_ff @(posedge i_clk) begin
        if (w_map_we) mem_map[w_map_waddr] <= w_map_wdata;
        r_map_rd <= mem_map[IW'(w_in_pos)];
    end

    // Member list memory; the read fetches the current last member.
    always_ff @(posedge i_clk) begin
        if (w_list_we) mem_list[w_list_waddr] <= w_list_wdata;
        r_list_rd <= mem_list[IW'(r_count - CW'(1))];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + IW'(1);
            if (r_state == S_LOOK)  r_count <= n_count;
            if (w_out_load)         r_out_vld <= 1'b1;
            else if (m_tready)      r_out_vld <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode    <= w_in_mode;
            r_pos     <= w_in_pos;
            r_inrange <= (32'(w_in_pos) < CELLS);
        end
        if (r_state == S_LOOK) r_res <= w_res;
        if (w_out_load) r_out <= (r_state == S_LOOK) ? w_res : r_res;
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {4'b0000, r_out.member_count, r_out.slot, r_out.changed};

endmodule
